>>> sv/assert_macros.svh
// Assertion macros included by the note tone generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/ntg_pkg.sv
// Package for the note tone generator: field codes, widths and the note ROMs.
`timescale 1ns / 1ps
`default_nettype none

package ntg_pkg;

    localparam int HALF_W  = 15;
    localparam int PER_W   = 10;
    localparam int BLK_W   = 11;
    localparam int DUR_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int CYC_W   = 10;

    // Action codes carried on the input tuser bit.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Accidental codes.
    localparam logic [1:0] ACC_NATURAL = 2'd0;
    localparam logic [1:0] ACC_FLAT    = 2'd1;
    localparam logic [1:0] ACC_SHARP   = 2'd2;

    localparam logic [2:0] PITCH_B = 3'd6;

    // floor(d / 50) as floor((d >> 1) * 20972 >> 19), exact for 16-bit d.
    localparam int          DIV25_SHIFT = 19;
    localparam logic [14:0] DIV25_MULT  = 15'd20972;

    // Octave-1 half period in microseconds, truncated: [pitch][accidental].
    localparam logic [HALF_W-1:0] HALF_ROM [7][3] = '{
        '{15'd15290, 15'd16199, 15'd14432},
        '{15'd13620, 15'd14430, 15'd12855},
        '{15'd12132, 15'd12854, 15'd11452},
        '{15'd11454, 15'd12135, 15'd10811},
        '{15'd10204, 15'd10810, 15'd9631},
        '{15'd9090,  15'd9631,  15'd8580},
        '{15'd8098,  15'd8580,  15'd7643}
    };

    // Octave-1 periods per 50 ms block with 8 fractional bits: [pitch][accidental].
    localparam logic [CYC_W-1:0] CYC_ROM [7][3] = '{
        '{10'd418, 10'd395, 10'd443},
        '{10'd469, 10'd443, 10'd497},
        '{10'd527, 10'd497, 10'd558},
        '{10'd558, 10'd527, 10'd591},
        '{10'd627, 10'd591, 10'd664},
        '{10'd704, 10'd664, 10'd745},
        '{10'd790, 10'd745, 10'd837}
    };

endpackage

`default_nettype wire

>>> sv/note_tone_generator_core.sv
// Each result beat is registered and presented in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while m_axis_tready is high; s_axis_tready
//   drops while a result beat waits in the output register.
// The note lookup, octave shift and divide by 50 all settle in the accept cycle.
// Reset: rst_n clears the tone state to idle, the pin low and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module note_tone_generator_core
    import ntg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pitch[2:0], accidental[4:3], octave[8:5], duration_ms[24:9], zero fill
    input  wire logic [31:0] s_axis_tdata,
    // action[0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pin_level[0], busy_res[1], note_done[2], rejected[3], zero fill
    output logic [7:0]       m_axis_tdata
);

    logic [HALF_W-1:0] half_len_reg, half_len_next;
    logic [HALF_W-1:0] half_cnt_reg, half_cnt_next;
    logic              phase_reg, phase_next;
    logic [PER_W-1:0]  per_block_reg, per_block_next;
    logic [PER_W-1:0]  per_cnt_reg, per_cnt_next;
    logic [BLK_W-1:0]  blocks_reg, blocks_next;
    logic              active_reg, active_next;
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_data_reg, out_data_next;

    logic              accept;
    logic              action;
    logic [2:0]        pitch;
    logic [1:0]        accidental;
    logic [3:0]        octave;
    logic [DUR_W-1:0]  duration_ms;

    logic [2:0]        pitch_sel;
    logic [1:0]        acc_sel;
    logic [2:0]        shift_k;
    logic [HALF_W-1:0] half_shifted;
    logic [HALF_W-1:0] half_new;
    logic [CYC_W+6:0]  cyc_shifted;
    logic [PER_W-1:0]  per_new;
    logic [29:0]       div_prod;
    logic [BLK_W-1:0]  blocks_new;
    logic              done;
    logic              rej;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_data_reg};

    assign action      = s_axis_tuser[0];
    assign pitch       = s_axis_tdata[2:0];
    assign accidental  = s_axis_tdata[4:3];
    assign octave      = s_axis_tdata[8:5];
    assign duration_ms = s_axis_tdata[24:9];

    // Note setup: clamp the fields, look up the ROMs, scale by octave and divide the duration into 50 ms blocks.
    always_comb
    begin
        pitch_sel = (pitch > PITCH_B) ? PITCH_B : pitch;
        acc_sel   = (accidental == ACC_NATURAL || accidental == ACC_FLAT ||
                     accidental == ACC_SHARP) ? accidental : ACC_NATURAL;
        if (octave == 4'd0)
            shift_k = 3'd0;
        else if (octave > 4'd8)
            shift_k = 3'd7;
        else
            shift_k = 3'(octave - 4'd1);

        half_shifted = HALF_ROM[pitch_sel][acc_sel] >> shift_k;
        half_new     = (half_shifted == '0) ? HALF_W'(1) : half_shifted;

        cyc_shifted  = {7'b0, CYC_ROM[pitch_sel][acc_sel]} << shift_k;
        per_new      = PER_W'(cyc_shifted[CYC_W+6:FRAC_W]) + PER_W'(1);

        div_prod     = 30'(duration_ms[DUR_W-1:1]) * 30'(DIV25_MULT);
        blocks_new   = div_prod[DIV25_SHIFT+BLK_W-1:DIV25_SHIFT];
    end

    // Tone state update and result for the accepted beat.
    always_comb
    begin
        half_len_next  = half_len_reg;
        half_cnt_next  = half_cnt_reg;
        phase_next     = phase_reg;
        per_block_next = per_block_reg;
        per_cnt_next   = per_cnt_reg;
        blocks_next    = blocks_reg;
        active_next    = active_reg;
        done           = 1'b0;
        rej            = 1'b0;

        if (accept)
        begin
            if (action == ACT_START)
            begin
                if (active_reg)
                begin
                    rej = 1'b1;
                end
                else if (blocks_new == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    half_len_next  = half_new;
                    per_block_next = per_new;
                    blocks_next    = blocks_new;
                    half_cnt_next  = '0;
                    per_cnt_next   = '0;
                    phase_next     = 1'b1;
                    active_next    = 1'b1;
                end
            end
            else if (active_reg)
            begin
                half_cnt_next = half_cnt_reg + HALF_W'(1);
                if (half_cnt_next >= half_len_reg)
                begin
                    half_cnt_next = '0;
                    if (phase_reg)
                    begin
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        per_cnt_next = per_cnt_reg + PER_W'(1);
                        phase_next   = 1'b1;
                        if (per_cnt_next >= per_block_reg)
                        begin
                            // End of block: count it down, stop after the last.
                            per_cnt_next = '0;
                            blocks_next  = blocks_reg - BLK_W'(1);
                            if (blocks_next == '0)
                            begin
                                active_next = 1'b0;
                                done        = 1'b1;
                                phase_next  = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    // Output register: load on accept, drop when the beat is taken.
    always_comb
    begin
        out_data_next = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {rej, done, active_next, phase_next};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_len_reg  <= '0;
            half_cnt_reg  <= '0;
            phase_reg     <= 1'b0;
            per_block_reg <= '0;
            per_cnt_reg   <= '0;
            blocks_reg    <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            half_len_reg  <= half_len_next;
            half_cnt_reg  <= half_cnt_next;
            phase_reg     <= phase_next;
            per_block_reg <= per_block_next;
            per_cnt_reg   <= per_cnt_next;
            blocks_reg    <= blocks_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `ASSERT_IMPLY(a_rej_busy, clk, rst_n, out_valid_reg && out_data_reg[3],
        out_data_reg[1], "rejected result without busy")
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, out_valid_reg && out_data_reg[2],
        !out_data_reg[1] && !out_data_reg[0], "note_done while busy or pin high")
    `ASSERT_IMPLY(a_active_len, clk, rst_n, active_reg,
        half_len_reg != '0 && blocks_reg != '0, "active note with zero length")
    `ASSERT_IMPLY(a_idle_pin, clk, rst_n, !active_reg, !phase_reg,
        "pin high while idle")

endmodule

`default_nettype wire
